FILE: sv/crc_pkg.sv
// shared types and constants for the circle raster canvas
`default_nettype none

package crc_pkg;

  // fixed field widths
  localparam int CoordW = 20;
  localparam int CharW  = 8;
  localparam int DimW   = 9;
  localparam int RcW    = 8;
  localparam int OpW    = 2;
  localparam int StatW  = 2;
  localparam int CfgAw  = 2;

  // input word layout, lowest bit first
  localparam int InDataW  = 88;
  localparam int OutDataW = 8;

  // default geometry
  localparam int MaxSideDef  = 256;
  localparam int FracBitsDef = 8;

  // register reset values
  localparam logic [DimW-1:0]  WidthRst  = 9'd256;
  localparam logic [DimW-1:0]  HeightRst = 9'd256;
  localparam logic [CharW-1:0] BgRst     = 8'd32;

  // paint characters that are refused
  localparam logic [CharW-1:0] NulChar     = 8'd0;
  localparam logic [CharW-1:0] NewlineChar = 8'd10;

  typedef enum logic [OpW-1:0] {
    OP_CLEAR = 2'd0,
    OP_DRAW  = 2'd1,
    OP_READ  = 2'd2
  } op_e;

  typedef enum logic [StatW-1:0] {
    STATUS_OK         = 2'd0,
    STATUS_BAD_CIRCLE = 2'd1,
    STATUS_OUTSIDE    = 2'd2
  } status_e;

  typedef enum logic [CfgAw-1:0] {
    REG_WIDTH  = 2'd0,
    REG_HEIGHT = 2'd1,
    REG_BG     = 2'd2
  } cfg_reg_e;

  // magnitude of a signed coordinate, the most negative value maps to 2^19
  function automatic logic [CoordW-1:0] coord_abs(input logic [CoordW-1:0] v);
    coord_abs = v[CoordW-1] ? (~v + CoordW'(1)) : v;
  endfunction

endpackage

`default_nettype wire

FILE: sv/circle_raster_canvas.sv
// character canvas with clear, filled or outlined circle draw and cell read
//
// Commands enter on the s_axis channel (op in tuser, arguments in tdata) and
// each one returns exactly one word on m_axis (status in tuser, character in
// tdata). The block works on one command at a time; s_axis_tready_o is high
// only while it waits for a command.
// Clear writes one canvas cell per cycle. Draw first has a shift-add squarer
// form the squares of center x, center y, radius and radius minus one, then
// one add-and-compare unit visits every cell in use, keeping the squared
// distances up to date by incremental adds. Read goes through the registered
// port of the canvas memory. An invalid circle, an unused op or a zero-sized
// canvas answers with no squaring or sweep.
// The result sits in an output register; a new command is taken while it
// waits, and a finished command holds until the receiver takes the old word.
// Reset sets width and height to 256 and the background to a space; the
// canvas contents are undefined until a clear has covered them, there is no
// clearing pass. Configuration writes are always taken (cfg_ready_o high)
// and are meant for times when no command is in flight.
`default_nettype none

module circle_raster_canvas #(
  parameter int MAX_SIDE  = crc_pkg::MaxSideDef,
  parameter int FRAC_BITS = crc_pkg::FracBitsDef
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  // configuration write channel
  input  wire logic                         cfg_valid_i,
  output      logic                         cfg_ready_o,
  input  wire logic [crc_pkg::CfgAw-1:0]    cfg_addr_i,
  input  wire logic [crc_pkg::DimW-1:0]     cfg_data_i,
  // command channel
  input  wire logic                         s_axis_tvalid_i,
  output      logic                         s_axis_tready_o,
  // center_x[19:0] center_y[39:20] radius[59:40] filled[60] paint_char[68:61]
  // read_row[76:69] read_col[84:77] zero[87:85]
  input  wire logic [crc_pkg::InDataW-1:0]  s_axis_tdata_i,
  // op[1:0]
  input  wire logic [crc_pkg::OpW-1:0]      s_axis_tuser_i,
  // result channel
  output      logic                         m_axis_tvalid_o,
  input  wire logic                         m_axis_tready_i,
  // cell_char[7:0]
  output      logic [crc_pkg::OutDataW-1:0] m_axis_tdata_o,
  // status[1:0]
  output      logic [crc_pkg::StatW-1:0]    m_axis_tuser_o
);

  localparam int MagW  = crc_pkg::CoordW;
  localparam int AccW  = 2 * MagW;
  localparam int CW    = $clog2(MAX_SIDE + 1);
  localparam int IW    = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1;
  localparam int Depth = MAX_SIDE * MAX_SIDE;
  localparam int AW    = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int OneFx = 1 << FRAC_BITS;
  localparam int DW    = $clog2(MAX_SIDE * OneFx + (1 << MagW)) + 2;
  localparam int SQW   = 2 * DW;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SQUARE,
    ST_SWEEP,
    ST_FINISH
  } state_e;

  // field unpacking
  logic signed [MagW-1:0]           in_cx, in_cy, in_rad;
  logic                             in_fill;
  logic [crc_pkg::CharW-1:0]        in_char;
  logic [crc_pkg::RcW-1:0]          in_row, in_col;

  assign in_cx   = s_axis_tdata_i[19:0];
  assign in_cy   = s_axis_tdata_i[39:20];
  assign in_rad  = s_axis_tdata_i[59:40];
  assign in_fill = s_axis_tdata_i[60];
  assign in_char = s_axis_tdata_i[68:61];
  assign in_row  = s_axis_tdata_i[76:69];
  assign in_col  = s_axis_tdata_i[84:77];

  // configuration registers
  logic [crc_pkg::DimW-1:0]  cfg_width_q, cfg_height_q;
  logic [crc_pkg::CharW-1:0] bg_char_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_width_q  <= crc_pkg::WidthRst;
      cfg_height_q <= crc_pkg::HeightRst;
      bg_char_q    <= crc_pkg::BgRst;
    end else if (cfg_valid_i) begin
      case (crc_pkg::cfg_reg_e'(cfg_addr_i))
        crc_pkg::REG_WIDTH:  cfg_width_q  <= cfg_data_i;
        crc_pkg::REG_HEIGHT: cfg_height_q <= cfg_data_i;
        crc_pkg::REG_BG:     bg_char_q    <= cfg_data_i[crc_pkg::CharW-1:0];
        default: ;
      endcase
    end
  end

  // dimensions clamped to the canvas size
  logic [CW-1:0] w_eff, h_eff;
  assign w_eff = (int'(cfg_width_q) > MAX_SIDE) ? CW'(MAX_SIDE) : CW'(cfg_width_q);
  assign h_eff = (int'(cfg_height_q) > MAX_SIDE) ? CW'(MAX_SIDE) : CW'(cfg_height_q);

  // state and datapath registers
  state_e                      state_q, state_d;
  logic                        m_valid_q, m_valid_d;
  logic [crc_pkg::CharW-1:0]   m_data_q, m_data_d;
  logic [crc_pkg::StatW-1:0]   m_user_q, m_user_d;

  logic [crc_pkg::StatW-1:0]   status_q, status_d;
  logic                        rd_ok_q, rd_ok_d;
  logic                        is_draw_q, is_draw_d;
  logic                        fill_q, fill_d;
  logic [crc_pkg::CharW-1:0]   char_q, char_d;
  logic signed [MagW-1:0]      cx_q, cx_d, cy_q, cy_d, rad_q, rad_d;
  logic [1:0]                  sq_idx_q, sq_idx_d;
  logic [$clog2(MagW)-1:0]     bit_cnt_q, bit_cnt_d;
  logic [AccW-1:0]             mul_a_q, mul_a_d, acc_q, acc_d;
  logic [MagW-1:0]             mul_b_q, mul_b_d;
  logic [SQW-1:0]              cxsq_q, cxsq_d, dxsq_q, dxsq_d, dysq_q, dysq_d;
  logic [SQW-1:0]              rsq_q, rsq_d, isq_q, isq_d;
  logic                        inner_neg_q, inner_neg_d;
  logic signed [DW-1:0]        dx_q, dx_d, dy_q, dy_d;
  logic [IW-1:0]               col_q, col_d, row_q, row_d;
  logic [AW-1:0]               addr_q, addr_d, rowbase_q, rowbase_d;

  // canvas memory
  logic [crc_pkg::CharW-1:0]   mem [Depth];
  logic [crc_pkg::CharW-1:0]   mem_rdata_q;
  logic                        wr_en, rd_en;
  logic [AW-1:0]               rd_addr;

  // combinational helpers
  logic signed [MagW:0]        inner;
  logic [MagW-1:0]             next_op;
  logic [AccW-1:0]             acc_next;
  logic [SQW-1:0]              d_sum, dx_delta, dy_delta;
  logic signed [DW:0]          dx_lin, dy_lin;
  logic                        in_circ, outline, col_last, row_last;
  logic                        rad_bad, dims_zero;

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;
  assign m_axis_tuser_o  = m_user_q;

  assign inner    = $signed({rad_q[MagW-1], rad_q}) - $signed((MagW + 1)'(OneFx));
  assign rad_bad  = in_rad[MagW-1] || (in_rad == '0) || (in_char == crc_pkg::NulChar) ||
                    (in_char == crc_pkg::NewlineChar);
  assign dims_zero = (w_eff == '0) || (h_eff == '0);
  assign rd_addr  = AW'(int'(in_row) * MAX_SIDE + int'(in_col));

  // next squarer operand after each square: cy, radius, radius minus one
  always_comb begin
    case (sq_idx_q)
      2'd0:    next_op = crc_pkg::coord_abs(cy_q);
      2'd1:    next_op = crc_pkg::coord_abs(rad_q);
      2'd2:    next_op = inner[MagW-1:0];
      default: next_op = '0;
    endcase
  end

  // shift-add squarer step
  assign acc_next = acc_q + (mul_b_q[0] ? mul_a_q : '0);

  // squared distance of the current cell and the incremental updates
  assign d_sum    = dxsq_q + dysq_q;
  assign in_circ  = (d_sum <= rsq_q);
  assign outline  = inner_neg_q || (d_sum > isq_q);
  assign dx_lin   = $signed({dx_q, 1'b0}) + $signed((DW + 1)'(OneFx));
  assign dy_lin   = $signed({dy_q, 1'b0}) + $signed((DW + 1)'(OneFx));
  assign dx_delta = SQW'(dx_lin) << FRAC_BITS;
  assign dy_delta = SQW'(dy_lin) << FRAC_BITS;
  assign col_last = (CW'(col_q) == w_eff - CW'(1));
  assign row_last = (CW'(row_q) == h_eff - CW'(1));

  // sequencer next state
  always_comb begin
    state_d     = state_q;
    m_valid_d   = m_valid_q;
    m_data_d    = m_data_q;
    m_user_d    = m_user_q;
    status_d    = status_q;
    rd_ok_d     = rd_ok_q;
    is_draw_d   = is_draw_q;
    fill_d      = fill_q;
    char_d      = char_q;
    cx_d        = cx_q;
    cy_d        = cy_q;
    rad_d       = rad_q;
    sq_idx_d    = sq_idx_q;
    bit_cnt_d   = bit_cnt_q;
    mul_a_d     = mul_a_q;
    mul_b_d     = mul_b_q;
    acc_d       = acc_q;
    cxsq_d      = cxsq_q;
    dxsq_d      = dxsq_q;
    dysq_d      = dysq_q;
    rsq_d       = rsq_q;
    isq_d       = isq_q;
    inner_neg_d = inner_neg_q;
    dx_d        = dx_q;
    dy_d        = dy_q;
    col_d       = col_q;
    row_d       = row_q;
    addr_d      = addr_q;
    rowbase_d   = rowbase_q;
    wr_en       = 1'b0;
    rd_en       = 1'b0;

    // receiver took the word
    if (m_valid_q && m_axis_tready_i) begin
      m_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid_i) begin
          status_d  = crc_pkg::STATUS_OK;
          rd_ok_d   = 1'b0;
          col_d     = '0;
          row_d     = '0;
          addr_d    = '0;
          rowbase_d = '0;
          state_d   = ST_FINISH;
          case (crc_pkg::op_e'(s_axis_tuser_i))
            crc_pkg::OP_CLEAR: begin
              is_draw_d = 1'b0;
              char_d    = bg_char_q;
              if (!dims_zero) begin
                state_d = ST_SWEEP;
              end
            end
            crc_pkg::OP_DRAW: begin
              if (rad_bad) begin
                status_d = crc_pkg::STATUS_BAD_CIRCLE;
              end else if (!dims_zero) begin
                is_draw_d = 1'b1;
                fill_d    = in_fill;
                char_d    = in_char;
                cx_d      = in_cx;
                cy_d      = in_cy;
                rad_d     = in_rad;
                dx_d      = -(DW'(in_cx));
                dy_d      = -(DW'(in_cy));
                sq_idx_d  = '0;
                bit_cnt_d = '0;
                acc_d     = '0;
                mul_b_d   = crc_pkg::coord_abs(in_cx);
                mul_a_d   = AccW'(crc_pkg::coord_abs(in_cx));
                state_d   = ST_SQUARE;
              end
            end
            crc_pkg::OP_READ: begin
              if (int'(in_row) >= int'(h_eff) || int'(in_col) >= int'(w_eff)) begin
                status_d = crc_pkg::STATUS_OUTSIDE;
              end else begin
                rd_en   = 1'b1;
                rd_ok_d = 1'b1;
              end
            end
            default: ;
          endcase
        end
      end

      ST_SQUARE: begin
        acc_d     = acc_next;
        mul_a_d   = mul_a_q << 1;
        mul_b_d   = mul_b_q >> 1;
        bit_cnt_d = bit_cnt_q + 1'b1;
        if (int'(bit_cnt_q) == MagW - 1) begin
          case (sq_idx_q)
            2'd0: begin
              cxsq_d = SQW'(acc_next);
              dxsq_d = SQW'(acc_next);
            end
            2'd1:    dysq_d = SQW'(acc_next);
            2'd2:    rsq_d  = SQW'(acc_next);
            default: isq_d  = SQW'(acc_next);
          endcase
          bit_cnt_d = '0;
          sq_idx_d  = sq_idx_q + 1'b1;
          acc_d     = '0;
          mul_b_d   = next_op;
          mul_a_d   = AccW'(next_op);
          if (sq_idx_q == 2'd3) begin
            inner_neg_d = inner[MagW];
            state_d     = ST_SWEEP;
          end
        end
      end

      ST_SWEEP: begin
        wr_en = !is_draw_q || (in_circ && (outline || fill_q));
        if (col_last) begin
          col_d  = '0;
          dx_d   = -(DW'(cx_q));
          dxsq_d = cxsq_q;
          if (row_last) begin
            state_d = ST_FINISH;
          end else begin
            row_d     = row_q + IW'(1);
            rowbase_d = rowbase_q + AW'(MAX_SIDE);
            addr_d    = rowbase_q + AW'(MAX_SIDE);
            dy_d      = dy_q + DW'(OneFx);
            dysq_d    = dysq_q + dy_delta;
          end
        end else begin
          col_d  = col_q + IW'(1);
          addr_d = addr_q + AW'(1);
          dx_d   = dx_q + DW'(OneFx);
          dxsq_d = dxsq_q + dx_delta;
        end
      end

      ST_FINISH: begin
        if (!m_valid_q || m_axis_tready_i) begin
          m_valid_d = 1'b1;
          m_user_d  = status_q;
          m_data_d  = rd_ok_q ? mem_rdata_q : '0;
          state_d   = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  // state and output word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      m_valid_q <= 1'b0;
      m_data_q  <= '0;
      m_user_q  <= '0;
    end else begin
      state_q   <= state_d;
      m_valid_q <= m_valid_d;
      m_data_q  <= m_data_d;
      m_user_q  <= m_user_d;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    status_q    <= status_d;
    rd_ok_q     <= rd_ok_d;
    is_draw_q   <= is_draw_d;
    fill_q      <= fill_d;
    char_q      <= char_d;
    cx_q        <= cx_d;
    cy_q        <= cy_d;
    rad_q       <= rad_d;
    sq_idx_q    <= sq_idx_d;
    bit_cnt_q   <= bit_cnt_d;
    mul_a_q     <= mul_a_d;
    mul_b_q     <= mul_b_d;
    acc_q       <= acc_d;
    cxsq_q      <= cxsq_d;
    dxsq_q      <= dxsq_d;
    dysq_q      <= dysq_d;
    rsq_q       <= rsq_d;
    isq_q       <= isq_d;
    inner_neg_q <= inner_neg_d;
    dx_q        <= dx_d;
    dy_q        <= dy_d;
    col_q       <= col_d;
    row_q       <= row_d;
    addr_q      <= addr_d;
    rowbase_q   <= rowbase_d;
  end

  // canvas write port
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[addr_q] <= char_q;
    end
  end

  // canvas read port
  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      mem_rdata_q <= mem[rd_addr];
    end
  end

  // sweep address tracks row base plus column
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SWEEP) |-> (addr_q == rowbase_q + AW'(col_q)))
    else $error("sweep address out of step with column");

  // sweep stays inside the canvas in use
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SWEEP) |-> ((CW'(col_q) < w_eff) && (CW'(row_q) < h_eff)))
    else $error("sweep outside canvas");

  // a finished command reaches the output once the slot is free
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ST_FINISH) && (!m_valid_q || m_axis_tready_i)) |=>
      (m_axis_tvalid_o && (state_q == ST_IDLE)))
    else $error("finished command not delivered");

  // only a good read carries a character
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_valid_q && (m_user_q != crc_pkg::STATUS_OK)) |-> (m_data_q == '0))
    else $error("character on an error word");

  // squarer bit counter stays in range
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SQUARE) |-> (int'(bit_cnt_q) < MagW))
    else $error("squarer bit counter overrun");

endmodule

`default_nettype wire

FILE: tb/tb_circle_raster_canvas.sv
// testbench for the circle raster canvas: directed table, random commands, reply checks
`timescale 1ns / 1ps

module tb_circle_raster_canvas;
  import crc_pkg::*;

  localparam int Side     = MaxSideDef;
  localparam int CellUnit = 1 << FracBitsDef;

  // op and register index with no name in the package
  localparam logic [OpW-1:0]   OP_UNUSED  = 2'd3;
  localparam logic [CfgAw-1:0] REG_UNUSED = 2'd3;

  // geometry of the directed part
  localparam logic [DimW-1:0] DirW  = 9'd16;
  localparam logic [DimW-1:0] DirH  = 9'd12;
  localparam logic [CharW-1:0] DirBg = 8'h2E;

  typedef struct {
    logic [OpW-1:0]           op;
    logic signed [CoordW-1:0] center_x;
    logic signed [CoordW-1:0] center_y;
    logic signed [CoordW-1:0] radius;
    logic                     filled;
    logic [CharW-1:0]         paint_char;
    logic [RcW-1:0]           read_row;
    logic [RcW-1:0]           read_col;
  } cmd_t;

  typedef struct packed {
    logic [StatW-1:0] status;
    logic [CharW-1:0] ch;
  } reply_t;

  typedef struct {
    cmd_t   cmd;
    bit     fixed;
    reply_t reply;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_valid = 1'b0;
  logic [CfgAw-1:0] cfg_addr = '0;
  logic [DimW-1:0] cfg_data = '0;
  logic s_tvalid = 1'b0;
  logic [InDataW-1:0] s_tdata = '0;
  logic [OpW-1:0] s_tuser = '0;
  logic m_tready = 1'b0;

  logic cfg_ready;
  logic s_tready;
  logic m_tvalid;
  logic [OutDataW-1:0] m_tdata;
  logic [StatW-1:0] m_tuser;

  // shadow of the canvas and its registers
  logic [CharW-1:0] canvas_mem [0:Side*Side-1];
  bit cell_set [0:Side*Side-1];
  logic [DimW-1:0] cfg_w = WidthRst;
  logic [DimW-1:0] cfg_h = HeightRst;
  logic [CharW-1:0] cfg_bg = BgRst;

  reply_t pending_replies[$];
  int unsigned mismatches = 0;
  int unsigned send_idle_pct = 0;
  int unsigned stall_pct = 0;

  always #1 clk = ~clk;

  circle_raster_canvas u_dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready),
    .cfg_addr_i      (cfg_addr),
    .cfg_data_i      (cfg_data),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tuser_o  (m_tuser)
  );

  // dimension in use, oversized values saturate
  function automatic int unsigned side_in_use(logic [DimW-1:0] v);
    return (v > Side) ? Side : int'(v);
  endfunction

  // apply one command to the shadow canvas and return its reply
  function automatic reply_t apply_command(cmd_t c);
    reply_t rep;
    int unsigned w, h;
    longint cx, cy, rad, rsq, inner, isq, dx, dy, d;
    rep = '0;
    w = side_in_use(cfg_w);
    h = side_in_use(cfg_h);
    case (c.op)
      OP_CLEAR: begin
        for (int unsigned r = 0; r < h; r++)
          for (int unsigned col = 0; col < w; col++) begin
            canvas_mem[r*Side+col] = cfg_bg;
            cell_set[r*Side+col] = 1'b1;
          end
      end
      OP_DRAW: begin
        cx = longint'(c.center_x);
        cy = longint'(c.center_y);
        rad = longint'(c.radius);
        if (rad <= 0 || c.paint_char == NulChar || c.paint_char == NewlineChar) begin
          rep.status = STATUS_BAD_CIRCLE;
        end else begin
          rsq = rad * rad;
          inner = rad - CellUnit;
          isq = inner * inner;
          for (int unsigned r = 0; r < h; r++) begin
            dy = (longint'(r) <<< FracBitsDef) - cy;
            for (int unsigned col = 0; col < w; col++) begin
              dx = (longint'(col) <<< FracBitsDef) - cx;
              d = dx * dx + dy * dy;
              // outline ring always, interior only when filled
              if (d <= rsq && (inner < 0 || d > isq || c.filled))
                canvas_mem[r*Side+col] = c.paint_char;
            end
          end
        end
      end
      OP_READ: begin
        if (c.read_row >= h || c.read_col >= w)
          rep.status = STATUS_OUTSIDE;
        else
          rep.ch = canvas_mem[c.read_row*Side+c.read_col];
      end
      default: ;
    endcase
    return rep;
  endfunction

  function automatic dir_row_t mk_row(logic [OpW-1:0] op, int cx, int cy, int rad, int fill,
                                      logic [CharW-1:0] ch, logic [RcW-1:0] row,
                                      logic [RcW-1:0] col, int fixed,
                                      logic [StatW-1:0] st, logic [CharW-1:0] rch);
    dir_row_t t;
    t.cmd.op = op;
    t.cmd.center_x = cx[CoordW-1:0];
    t.cmd.center_y = cy[CoordW-1:0];
    t.cmd.radius = rad[CoordW-1:0];
    t.cmd.filled = fill[0];
    t.cmd.paint_char = ch;
    t.cmd.read_row = row;
    t.cmd.read_col = col;
    t.fixed = fixed[0];
    t.reply.status = st;
    t.reply.ch = rch;
    return t;
  endfunction

  // random command, mostly circles near the canvas and reads of written cells
  function automatic cmd_t next_cmd(int unsigned draw_pct);
    cmd_t c;
    int unsigned w, h, roll, reach;
    int v;
    w = side_in_use(cfg_w);
    h = side_in_use(cfg_h);
    reach = ((w > h) ? w : h) + 2;
    c.center_x = CoordW'($urandom);
    c.center_y = CoordW'($urandom);
    c.radius = CoordW'($urandom);
    c.filled = 1'($urandom);
    c.paint_char = CharW'($urandom);
    c.read_row = RcW'($urandom);
    c.read_col = RcW'($urandom);
    roll = $urandom_range(99);
    if (roll < 6)
      c.op = OP_CLEAR;
    else if (roll < 6 + draw_pct)
      c.op = OP_DRAW;
    else if (roll < 95)
      c.op = OP_READ;
    else
      c.op = OP_UNUSED;

    if (c.op == OP_DRAW) begin
      roll = $urandom_range(9);
      if (roll < 7) begin
        v = int'($urandom_range(reach * CellUnit)) - CellUnit;
        c.center_x = v[CoordW-1:0];
        v = int'($urandom_range(reach * CellUnit)) - CellUnit;
        c.center_y = v[CoordW-1:0];
        v = int'($urandom_range(reach * CellUnit, 1));
        c.radius = v[CoordW-1:0];
      end else if (roll == 7) begin
        // wide circle anywhere in the coordinate range
        c.radius[CoordW-1] = 1'b0;
        if (c.radius == 0)
          c.radius = CoordW'(1);
      end else if (roll == 8) begin
        v = -int'($urandom_range(CellUnit));
        c.radius = v[CoordW-1:0];
      end
      if (roll == 9)
        c.paint_char = $urandom_range(1) ? NulChar : NewlineChar;
      else begin
        c.paint_char = CharW'($urandom_range(255, 1));
        if (c.paint_char == NewlineChar)
          c.paint_char = "*";
      end
    end

    if (c.op == OP_READ && w != 0 && h != 0 && $urandom_range(4) != 0) begin
      c.read_row = RcW'($urandom_range(h - 1));
      c.read_col = RcW'($urandom_range(w - 1));
    end
    // never read a cell in use that nothing has written: clear instead
    if (c.op == OP_READ && c.read_row < h && c.read_col < w &&
        !cell_set[c.read_row*Side+c.read_col])
      c.op = OP_CLEAR;
    return c;
  endfunction

  // one register write, valid left high for a following write
  task automatic cfg_put(input logic [CfgAw-1:0] addr, input logic [DimW-1:0] val);
    cfg_valid <= 1'b1;
    cfg_addr <= addr;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    case (addr)
      REG_WIDTH:  cfg_w = val;
      REG_HEIGHT: cfg_h = val;
      REG_BG:     cfg_bg = val[CharW-1:0];
      default: ;
    endcase
  endtask

  task automatic write_regs(input logic [DimW-1:0] w, input logic [DimW-1:0] h,
                            input logic [CharW-1:0] bg, input bit poke_unused);
    cfg_put(REG_WIDTH, w);
    cfg_put(REG_HEIGHT, h);
    cfg_put(REG_BG, {1'b0, bg});
    if (poke_unused)
      cfg_put(REG_UNUSED, '1);
    cfg_valid <= 1'b0;
  endtask

  // send one command word, then record the reply it should produce
  task automatic send_cmd(input cmd_t c, input bit fixed, input reply_t fixed_reply);
    reply_t calc;
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= c.op;
    s_tdata <= {3'b000, c.read_col, c.read_row, c.paint_char, c.filled,
                c.radius, c.center_y, c.center_x};
    do @(posedge clk); while (!s_tready);
    calc = apply_command(c);
    pending_replies.push_back(fixed ? fixed_reply : calc);
  endtask

  task automatic run_batch(input int unsigned n, input int unsigned draw_pct);
    for (int unsigned i = 0; i < n; i++)
      send_cmd(next_cmd(draw_pct), 1'b0, '0);
  endtask

  // stop sending and wait until every reply is back
  task automatic drain();
    s_tvalid <= 1'b0;
    while (pending_replies.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // reply checking and receiver stalls
  initial begin : reply_check
    reply_t want;
    forever begin
      @(posedge clk);
      if (m_tvalid && m_tready) begin
        if (pending_replies.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected word, got status %0d char %02h", $time, m_tuser, m_tdata);
        end else begin
          want = pending_replies.pop_front();
          if (m_tuser !== want.status || m_tdata !== want.ch) begin
            mismatches++;
            $display("%0t: expected status %0d char %02h, got status %0d char %02h",
                     $time, want.status, want.ch, m_tuser, m_tdata);
          end
        end
      end
      m_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  initial begin : stimulus
    dir_row_t dir_rows[$];
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed table on a 16 x 12 canvas
    write_regs(DirW, DirH, DirBg, 1'b0);
    dir_rows = '{
      mk_row(OP_UNUSED, 0, 0, 0, 0, 8'h00, 8'd0, 8'd0, 1, STATUS_OK, 8'h00),
      mk_row(OP_READ, 0, 0, 0, 0, 8'h00, 8'd255, 8'd255, 1, STATUS_OUTSIDE, 8'h00),
      mk_row(OP_CLEAR, 0, 0, 0, 0, 8'h00, 8'd0, 8'd0, 1, STATUS_OK, 8'h00),
      mk_row(OP_READ, 0, 0, 0, 0, 8'h00, 8'd0, 8'd0, 1, STATUS_OK, DirBg),
      // refused circles: zero and most negative radius, nul and newline paint
      mk_row(OP_DRAW, 8*CellUnit, 6*CellUnit, 0, 1, "X", 8'd0, 8'd0,
             1, STATUS_BAD_CIRCLE, 8'h00),
      mk_row(OP_DRAW, 8*CellUnit, 6*CellUnit, -524288, 1, "X", 8'd0, 8'd0,
             1, STATUS_BAD_CIRCLE, 8'h00),
      mk_row(OP_DRAW, 8*CellUnit, 6*CellUnit, 3*CellUnit, 1, NulChar, 8'd0, 8'd0,
             1, STATUS_BAD_CIRCLE, 8'h00),
      mk_row(OP_DRAW, 8*CellUnit, 6*CellUnit, 3*CellUnit, 1, NewlineChar, 8'd0, 8'd0,
             1, STATUS_BAD_CIRCLE, 8'h00),
      // coordinate extremes
      mk_row(OP_DRAW, 524287, 524287, 524287, 1, 8'hFF, 8'd0, 8'd0, 0, STATUS_OK, 8'h00),
      mk_row(OP_READ, 0, 0, 0, 0, 8'h00, 8'd11, 8'd15, 0, STATUS_OK, 8'h00),
      mk_row(OP_DRAW, -524288, -524288, 524287, 0, 8'h01, 8'd0, 8'd0, 0, STATUS_OK, 8'h00),
      mk_row(OP_READ, 0, 0, 0, 0, 8'h00, 8'd0, 8'd0, 0, STATUS_OK, 8'h00),
      // tiny circle with negative inner radius, unit circle, filled and ring
      mk_row(OP_DRAW, 8*CellUnit, 6*CellUnit, 1, 0, "A", 8'd0, 8'd0, 0, STATUS_OK, 8'h00),
      mk_row(OP_DRAW, 8*CellUnit, 6*CellUnit, CellUnit, 0, "B", 8'd0, 8'd0,
             0, STATUS_OK, 8'h00),
      mk_row(OP_DRAW, 4*CellUnit+128, 5*CellUnit, 5*CellUnit, 1, "C", 8'd0, 8'd0,
             0, STATUS_OK, 8'h00),
      mk_row(OP_DRAW, 11*CellUnit, 6*CellUnit, 4*CellUnit, 0, "o", 8'd0, 8'd0,
             0, STATUS_OK, 8'h00),
      mk_row(OP_READ, 0, 0, 0, 0, 8'h00, 8'd6, 8'd8, 0, STATUS_OK, 8'h00),
      mk_row(OP_READ, 0, 0, 0, 0, 8'h00, 8'd6, 8'd11, 0, STATUS_OK, 8'h00),
      mk_row(OP_READ, 0, 0, 0, 0, 8'h00, 8'd5, 8'd4, 0, STATUS_OK, 8'h00),
      mk_row(OP_READ, 0, 0, 0, 0, 8'h00, 8'd2, 8'd11, 0, STATUS_OK, 8'h00),
      // just past the last row and the last column
      mk_row(OP_READ, 0, 0, 0, 0, 8'h00, 8'd12, 8'd0, 1, STATUS_OUTSIDE, 8'h00),
      mk_row(OP_READ, 0, 0, 0, 0, 8'h00, 8'd0, 8'd16, 1, STATUS_OUTSIDE, 8'h00),
      mk_row(OP_CLEAR, 0, 0, 0, 0, 8'h00, 8'd0, 8'd0, 1, STATUS_OK, 8'h00),
      mk_row(OP_READ, 0, 0, 0, 0, 8'h00, 8'd3, 8'd3, 1, STATUS_OK, DirBg)
    };
    foreach (dir_rows[i])
      send_cmd(dir_rows[i].cmd, dir_rows[i].fixed, dir_rows[i].reply);
    drain();

    // single cell canvas, sender mostly idle
    write_regs(9'd1, 9'd1, 8'hFF, 1'b0);
    send_idle_pct = 87;
    stall_pct = 0;
    run_batch(12, 40);
    drain();

    // zero width, receiver mostly stalled
    write_regs(9'd0, 9'd256, 8'h5A, 1'b0);
    send_idle_pct = 0;
    stall_pct = 87;
    run_batch(8, 40);
    drain();

    // wide and short, both sides idling
    write_regs(9'd20, 9'd7, CharW'($urandom_range(255)), 1'b0);
    send_idle_pct = 32;
    stall_pct = 32;
    run_batch(25, 40);
    drain();

    // narrow and full height, no idling
    write_regs(9'd5, 9'd256, 8'h20, 1'b0);
    send_idle_pct = 0;
    stall_pct = 0;
    run_batch(15, 30);
    drain();

    // oversized dimensions saturate to the full canvas, few commands
    write_regs(9'd511, 9'd300, 8'h23, 1'b1);
    send_idle_pct = 87;
    stall_pct = 0;
    run_batch(7, 15);
    drain();

    // zero background on a square canvas
    write_regs(9'd16, 9'd16, 8'h00, 1'b0);
    send_idle_pct = 32;
    stall_pct = 32;
    run_batch(30, 40);
    drain();

    repeat (50) @(posedge clk);
    if (mismatches == 0 && pending_replies.size() == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

  // run limit
  initial begin : watchdog
    #10_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule

FILE: files.f
sv/crc_pkg.sv
sv/circle_raster_canvas.sv
tb/tb_circle_raster_canvas.sv
